// ===== rtl/smm_pkg.sv =====
// Shared types, constants and helper functions of the serial bank switch mapper.
`default_nettype none

package smm_pkg;

   localparam int unsigned MAX_PRG_BANKS = 32;
   localparam int unsigned MAX_CHR_BANKS = 16;

   localparam int unsigned PRG_CNT_W = 6;
   localparam int unsigned CHR_CNT_W = 5;
   localparam int unsigned BANK_W    = 5;
   localparam int unsigned DIVR_W    = 6;
   localparam int unsigned ADDR_W    = 16;
   localparam int unsigned DATA_W    = 8;
   localparam int unsigned PHYS_W    = 19;
   localparam int unsigned MIRROR_W  = 2;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DAT_W = 6;

   localparam logic [BANK_W-1:0] SHIFT_EMPTY = 5'h10;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PRG_BANK_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHR_BANK_COUNT = 1'b1;

   localparam logic [PRG_CNT_W-1:0] PRG_COUNT_RESET = 6'd2;
   localparam logic [CHR_CNT_W-1:0] CHR_COUNT_RESET = 5'd1;

   // Program modes that switch a single 16 KiB slot; the others switch a 32 KiB pair.
   localparam logic [1:0] PRG_MODE_SWITCH_HIGH = 2'd2;
   localparam logic [1:0] PRG_MODE_SWITCH_LOW  = 2'd3;

   typedef enum logic [2:0] {
      TGT_NONE   = 3'd0,
      TGT_CHR    = 3'd1,
      TGT_SRAM   = 3'd2,
      TGT_PRG    = 3'd3,
      TGT_MAPREG = 3'd4
   } target_type;

   // Mapper register chosen by bus address bits 14:13 of a serial write.
   typedef enum logic [1:0] {
      SEL_CONTROL = 2'd0,
      SEL_CHR0    = 2'd1,
      SEL_CHR1    = 2'd2,
      SEL_PRG     = 2'd3
   } reg_sel_type;

   typedef enum logic [1:0] {
      ST_IDLE     = 2'd0,
      ST_EXEC     = 2'd1,
      ST_MOD_WAIT = 2'd2,
      ST_RESULT   = 2'd3
   } ctrl_state_type;

   typedef struct packed {
      logic load_item;
      logic exec;
      logic commit;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic need_mod;
      logic mod_done;
      logic rsp_free;
   } dp_status_type;

   // Program bank count with zero taken as one and the top saturated.
   function automatic logic [PRG_CNT_W-1:0] eff_prg(input logic [PRG_CNT_W-1:0] cnt);
      logic [PRG_CNT_W-1:0] n;
      n = cnt;
      if (cnt == '0) begin
         n = PRG_CNT_W'(1);
      end else if (cnt > PRG_CNT_W'(MAX_PRG_BANKS)) begin
         n = PRG_CNT_W'(MAX_PRG_BANKS);
      end
      return n;
   endfunction

   // Character bank count in 8 KiB units, limited in the same way.
   function automatic logic [CHR_CNT_W-1:0] eff_chr(input logic [CHR_CNT_W-1:0] cnt);
      logic [CHR_CNT_W-1:0] n;
      n = cnt;
      if (cnt == '0) begin
         n = CHR_CNT_W'(1);
      end else if (cnt > CHR_CNT_W'(MAX_CHR_BANKS)) begin
         n = CHR_CNT_W'(MAX_CHR_BANKS);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/smm_mod.sv =====
// Bit-serial remainder unit: reduces a bank index modulo a bank count.
`default_nettype none

module smm_mod
   import smm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [BANK_W-1:0] dividend,
   input  wire logic [DIVR_W-1:0] divisor,
   output logic                   done,
   output logic [BANK_W-1:0]      remainder
);

   logic              busy_ff;
   logic              done_ff;
   logic [2:0]        step_ff;
   logic [BANK_W-1:0] dvd_ff;
   logic [DIVR_W-1:0] dvs_ff;
   logic [DIVR_W-1:0] rem_ff;
   logic [DIVR_W-1:0] shifted;
   logic [DIVR_W-1:0] rem_in;

   // The partial remainder stays below the divisor, so it fits in five bits before the shift.
   always_comb begin
      shifted = {rem_ff[BANK_W-1:0], dvd_ff[BANK_W-1]};
      rem_in  = (shifted >= dvs_ff) ? (shifted - dvs_ff) : shifted;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'(BANK_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[BANK_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff[BANK_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/smm_dp.sv =====
// Datapath: mapper registers, address translation, serial register and result register.
`default_nettype none

module smm_dp
   import smm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctrl_cmd_type         cmd,
   output dp_status_type             status,
   input  wire logic [23:0]          req_tdata,
   input  wire logic                 req_tuser,
   output logic [23:0]               rsp_tdata,
   output logic [2:0]                rsp_tuser,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   // Captured bus access.
   logic              item_action_ff;
   logic [ADDR_W-1:0] item_addr_ff;
   logic [DATA_W-1:0] item_data_ff;

   // Mapper state.
   logic [PRG_CNT_W-1:0] prg_count_ff;
   logic [CHR_CNT_W-1:0] chr_count_ff;
   logic [BANK_W-1:0]    shift_ff;
   logic [1:0]           prg_mode_ff;
   logic                 chr_mode_ff;
   logic [MIRROR_W-1:0]  mirror_ff;
   logic [MIRROR_W-1:0]  mirror_in;
   logic [BANK_W-1:0]    chr_slot_ff [2];
   logic [BANK_W-1:0]    prg_slot_ff [2];
   reg_sel_type          pend_sel_ff;

   // Result register.
   logic              rsp_valid_ff;
   logic [23:0]       rsp_tdata_ff;
   logic [2:0]        rsp_tuser_ff;

   logic [PRG_CNT_W-1:0] prg_eff;
   logic [DIVR_W-1:0]    chr_eff4;
   logic [PRG_CNT_W-1:0] new_prg_eff;
   logic [CHR_CNT_W-1:0] new_chr_eff;
   logic                 csr_write;

   logic [BANK_W-1:0] shift_value;
   logic              serial_wr;
   logic              commit_now;
   reg_sel_type       sel;
   logic              need_mod;
   logic              mod_start;
   logic [BANK_W-1:0] mod_dividend;
   logic [DIVR_W-1:0] mod_divisor;
   logic              mod_done;
   logic [BANK_W-1:0] mod_rem;
   logic [DIVR_W-1:0] rem_plus;
   logic [BANK_W-1:0] prg_pair_hi;

   target_type        res_target;
   logic [PHYS_W-1:0] res_phys;
   logic              res_write;

   assign prg_eff     = eff_prg(prg_count_ff);
   assign chr_eff4    = {eff_chr(chr_count_ff), 1'b0};
   assign new_prg_eff = eff_prg(csr_wdata);
   assign new_chr_eff = eff_chr(csr_wdata[CHR_CNT_W-1:0]);
   assign csr_write   = csr_valid && csr_ready;

   // Serial register decode for the captured access.
   always_comb begin
      shift_value = {item_data_ff[0], shift_ff[BANK_W-1:1]};
      serial_wr   = item_action_ff && item_addr_ff[15];
      commit_now  = serial_wr && !item_data_ff[7] && shift_ff[0];
      sel         = reg_sel_type'(item_addr_ff[14:13]);
      need_mod    = commit_now && (sel != SEL_CONTROL) &&
                    !((sel == SEL_CHR1) && !chr_mode_ff);
      mod_start   = cmd.exec && need_mod;
      if (sel == SEL_PRG) begin
         mod_divisor  = prg_eff;
         mod_dividend = prg_mode_ff[1] ? {1'b0, shift_value[3:0]}
                                       : {1'b0, shift_value[3:1], 1'b0};
      end else begin
         mod_divisor  = chr_eff4;
         mod_dividend = chr_mode_ff ? shift_value : {shift_value[4:1], 1'b0};
      end
      if (cmd.exec && commit_now && (sel == SEL_CONTROL)) begin
         mirror_in = shift_value[1:0];
      end else begin
         mirror_in = mirror_ff;
      end
   end

   smm_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (mod_divisor),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Upper bank of a 32 KiB program pair wraps to zero at the bank count.
   always_comb begin
      rem_plus    = {1'b0, mod_rem} + DIVR_W'(1);
      prg_pair_hi = (rem_plus == prg_eff) ? '0 : rem_plus[BANK_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_addr_ff   <= req_tdata[15:0];
         item_data_ff   <= req_tdata[23:16];
         item_action_ff <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_count_ff   <= PRG_COUNT_RESET;
         chr_count_ff   <= CHR_COUNT_RESET;
         shift_ff       <= SHIFT_EMPTY;
         prg_mode_ff    <= '0;
         chr_mode_ff    <= 1'b0;
         mirror_ff      <= '0;
         chr_slot_ff[0] <= '0;
         chr_slot_ff[1] <= BANK_W'(CHR_COUNT_RESET - 5'd1);
         prg_slot_ff[0] <= '0;
         prg_slot_ff[1] <= BANK_W'(PRG_COUNT_RESET - 6'd1);
         pend_sel_ff    <= SEL_CONTROL;
      end else begin
         mirror_ff <= mirror_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_PRG_BANK_COUNT: begin
                  prg_count_ff   <= csr_wdata;
                  prg_slot_ff[0] <= '0;
                  prg_slot_ff[1] <= BANK_W'(new_prg_eff - 6'd1);
               end
               CSR_CHR_BANK_COUNT: begin
                  chr_count_ff   <= csr_wdata[CHR_CNT_W-1:0];
                  chr_slot_ff[0] <= '0;
                  chr_slot_ff[1] <= BANK_W'(new_chr_eff - 5'd1);
               end
               default: begin
               end
            endcase
         end
         if (cmd.exec && serial_wr) begin
            if (item_data_ff[7] || shift_ff[0]) begin
               shift_ff <= SHIFT_EMPTY;
            end else begin
               shift_ff <= shift_value;
            end
            if (commit_now && (sel == SEL_CONTROL)) begin
               prg_mode_ff <= shift_value[3:2];
               chr_mode_ff <= shift_value[4];
            end
            pend_sel_ff <= sel;
         end
         if (cmd.commit) begin
            if (pend_sel_ff == SEL_PRG) begin
               case (prg_mode_ff)
                  PRG_MODE_SWITCH_HIGH: prg_slot_ff[1] <= mod_rem;
                  PRG_MODE_SWITCH_LOW:  prg_slot_ff[0] <= mod_rem;
                  default: begin
                     prg_slot_ff[0] <= mod_rem;
                     prg_slot_ff[1] <= prg_pair_hi;
                  end
               endcase
            end else if (!chr_mode_ff) begin
               // Even remainder of an even count: the odd partner never wraps.
               chr_slot_ff[0] <= mod_rem;
               chr_slot_ff[1] <= {mod_rem[BANK_W-1:1], 1'b1};
            end else if (pend_sel_ff == SEL_CHR1) begin
               chr_slot_ff[1] <= mod_rem;
            end else begin
               chr_slot_ff[0] <= mod_rem;
            end
         end
      end
   end

   // Address translation from the captured access and the current banks.
   always_comb begin
      res_target = TGT_NONE;
      res_phys   = '0;
      res_write  = 1'b0;
      if (item_addr_ff[15:13] == 3'b000) begin
         res_target = TGT_CHR;
         res_phys   = {2'b00, chr_slot_ff[item_addr_ff[12]], item_addr_ff[11:0]};
         res_write  = item_action_ff;
      end else if (item_addr_ff[15:13] == 3'b011) begin
         res_target = TGT_SRAM;
         res_phys   = {6'b0, item_addr_ff[12:0]};
         res_write  = item_action_ff;
      end else if (item_addr_ff[15]) begin
         if (item_action_ff) begin
            res_target = TGT_MAPREG;
            res_write  = 1'b1;
         end else begin
            res_target = TGT_PRG;
            res_phys   = {prg_slot_ff[item_addr_ff[14]], item_addr_ff[13:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_tdata_ff <= {2'b00, mirror_in, res_write, res_phys};
         rsp_tuser_ff <= res_target;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_tdata_ff;
   assign rsp_tuser       = rsp_tuser_ff;
   assign status.need_mod = need_mod;
   assign status.mod_done = mod_done;
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

endmodule

`default_nettype wire

// ===== rtl/smm_ctrl.sv =====
// Controller: sequences accept, execute, bank reduction and result transfer for one access.
`default_nettype none

module smm_ctrl
   import smm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.need_mod) begin
               state_in = ST_MOD_WAIT;
            end else if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_MOD_WAIT: begin
            if (status.mod_done) begin
               cmd.commit = 1'b1;
               state_in   = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/serial_bank_switch_mapper.sv =====
// Top level of the serial bank switch mapper: controller and datapath.
`default_nettype none

// Translates one bus access at a time into a target memory and a byte address, and feeds
// writes at 0x8000 and above into the five-bit serial register that loads the control,
// character bank and program bank registers. An access that does not complete a bank
// register has its result registered at the edge after its transfer, provided the result
// register is free, and the next access can then be taken. The fifth write to a bank
// register passes the execute, remainder-wait and result states before its result is
// registered; in the remainder-wait state the bit-serial remainder unit reduces the bank
// index modulo the bank count, one bit a cycle. A busy result register holds a result back
// while it stays full. The result register lets the next access be taken while a result
// waits. The user must write bank counts through the csr port only while no access is in
// progress; the block itself does not enforce this.

module serial_bank_switch_mapper
   import smm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [23:0]          req_tdata,  // bus_addr[15:0], wr_data[23:16]
   input  wire logic                 req_tuser,  // action
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [23:0]               rsp_tdata,  // phys_addr[18:0], is_write[19], mirroring[21:20]
   output logic [2:0]                rsp_tuser,  // target
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   smm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   smm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

`default_nettype wire
